FILE: rtl/spc_pkg.sv
// Shared types and constants of the strided zero-padded 2D convolution block.
package spc_pkg;

    localparam int PIX_W      = 16;
    localparam int PROD_W     = 32;
    localparam int SUM_W      = 35;
    localparam int OUT_IDX_W  = 9;
    localparam int DIM_W      = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;
    localparam int COEF_COLS  = 3;

    typedef logic signed [PIX_W-1:0] t_pixel;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [OUT_IDX_W-1:0] t_out_idx;
    typedef logic [DIM_W-1:0] t_dim;
    typedef logic [1:0] t_small;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // register indexes of the configuration port
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 4'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 4'd1;
    localparam t_cfg_idx CFG_KERNEL_SIZE  = 4'd2;
    localparam t_cfg_idx CFG_PAD_AMOUNT   = 4'd3;
    localparam t_cfg_idx CFG_STEP_SIZE    = 4'd4;
    localparam t_cfg_idx CFG_COEF_ROW0    = 4'd5;
    localparam t_cfg_idx CFG_COEF_ROW1    = 4'd6;
    localparam t_cfg_idx CFG_COEF_ROW2    = 4'd7;

    // reset values of the configuration registers
    localparam t_dim   RST_IMAGE_WIDTH  = 9'd8;
    localparam t_dim   RST_IMAGE_HEIGHT = 9'd8;
    localparam t_small RST_KERNEL_SIZE  = 2'd3;
    localparam t_small RST_PAD_AMOUNT   = 2'd0;
    localparam t_small RST_STEP_SIZE    = 2'd1;

endpackage

FILE: rtl/spc_stride_div.sv
// Quotient and exactness of a window coordinate divided by the stride (1, 2 or 3).
module spc_stride_div #(
    parameter int XW = 9
) (
    input  logic [XW-1:0]      i_x,
    input  spc_pkg::t_small    i_step,
    output logic [XW-1:0]      o_quot,
    output logic               o_exact
);

    // divide by three as a multiply by a rounded-up reciprocal, exact for XW-bit values
    localparam int SH = XW + 2;
    localparam int PW = SH + XW;
    localparam logic [PW-1:0] RECIP = PW'(((64'd1 << SH) + 64'd2) / 64'd3);

    logic [PW-1:0]   prod;
    logic [XW-1:0]   quot3;
    logic [XW+1:0]   back3;

    assign prod  = PW'(i_x) * RECIP;
    assign quot3 = prod[PW-1:SH];
    assign back3 = {1'b0, quot3, 1'b0} + {2'b00, quot3};

    always_comb begin
        case (i_step)
            2'd2: begin
                o_quot  = i_x >> 1;
                o_exact = ~i_x[0];
            end
            2'd3: begin
                o_quot  = quot3;
                o_exact = (back3 == {2'b00, i_x});
            end
            default: begin
                o_quot  = i_x;
                o_exact = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/strided_padded_conv2d_top.sv
// Top level of the streaming strided, zero-padded 2D convolution block.
//
// Takes one signed Q8.8 sample per cycle in raster order over the padded grid
// ((image_height + 2*pad_amount) rows by (image_width + 2*pad_amount) columns)
// and replaces samples at padding positions by zero. Whenever a kernel window
// whose top-left corner lies on the stride grid is complete, it returns the
// exact Q19.16 sum of the window products together with the output row and
// column, and flags the last result of the frame. After reset the line store
// is swept to zero, one column per cycle, over MAX_WIDTH + 2*MAX_PAD columns
// (260 by default); o_in_ready stays low during the sweep. After that one
// transaction is accepted every cycle. A result passes through line store
// read, window load with stride division, the parallel multipliers, row sums,
// and the final add into an eight-entry result queue. Input is held off only
// when that queue, counting the results still in the pipeline, is full.
// Configuration writes take effect at once; the user, not the block, must make
// them only while no transaction is in flight. The raster position is kept
// across writes and restarts at zero when it falls outside the new grid.
module strided_padded_conv2d_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_KERNEL = 3,
    parameter int MAX_PAD    = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  spc_pkg::t_pixel      i_pixel,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output spc_pkg::t_sum        o_conv_sum,
    output spc_pkg::t_out_idx    o_out_row,
    output spc_pkg::t_out_idx    o_out_col,
    output logic                 o_frame_done,
    input  logic                 i_cfg_wr_en,
    input  spc_pkg::t_cfg_idx    i_cfg_idx,
    input  spc_pkg::t_cfg_data   i_cfg_data
);

    import spc_pkg::*;

    localparam int MK       = MAX_KERNEL;
    localparam int KC       = (MK < 3) ? MK : 3;
    localparam int LINE_LEN = MAX_WIDTH + 2 * MAX_PAD;
    localparam int LR       = (MK > 1) ? MK - 1 : 1;
    localparam int CW       = $clog2(LINE_LEN + 1);
    localparam int AW       = $clog2(LINE_LEN);
    localparam int LW       = LR * PIX_W;
    localparam int FDEPTH   = 8;
    localparam int FPW      = $clog2(FDEPTH);
    localparam int FCW      = FPW + 1;
    localparam int RSUM_W   = PROD_W + 2;
    localparam int TSUM_W   = RSUM_W + 2;

    typedef struct packed {
        t_sum     sum;
        t_out_idx row;
        t_out_idx col;
        logic     done;
    } t_result;

    // configuration registers
    t_dim   r_cfg_w, r_cfg_h;
    t_small r_cfg_k, r_cfg_pad, r_cfg_step;
    logic [CFG_DATA_W-1:0] r_coef [KC];

    // effective sizes after clamping
    logic [CW-1:0] w_eff, h_eff, pw, ph;
    t_small        k_eff, p_eff, s_eff;

    // raster position and sweep
    logic [CW-1:0] r_grid_row, r_grid_col, n_grid_row, n_grid_col;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // current position decode
    logic          restart, is_pad, win_ok, last_pos, in_acc;
    logic [CW-1:0] cur_row, cur_col, top, left;
    t_pixel        cur_pix;

    // line store
    logic [LW-1:0] r_line_mem [LINE_LEN];
    logic [LW-1:0] r_line_rd, line_wdata, mem_wdata;
    logic [AW-1:0] mem_waddr;
    logic          mem_we, bypass;

    // stage 1: sample with its line store word
    logic          r_s1_vld, r_s1_win, r_s1_last;
    t_pixel        r_s1_pix;
    logic [CW-1:0] r_s1_col, r_s1_top, r_s1_left;
    logic [CW-1:0] qrow, qcol;
    logic          ex_row, ex_col;

    // window and later stages
    t_pixel   r_win [MK][MK];
    logic     r_s2_prod, r_s3_prod, r_s4_prod;
    t_result  r_s2_meta, r_s3_meta, r_s4_meta;
    t_prod    n_prod [KC][KC];
    t_prod    r_s3_mul [KC][KC];
    logic signed [RSUM_W-1:0] n_rsum [KC];
    logic signed [RSUM_W-1:0] r_s4_rsum [KC];
    logic signed [TSUM_W-1:0] tsum;

    // result queue
    t_result          r_fifo [FDEPTH];
    logic [FPW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FCW-1:0]   r_fcnt;
    logic [FCW:0]     credit;
    logic             push, pop;
    t_result          push_res;

    // ---------------------------------------------------------------
    // Configuration: take writes directly, ignore unknown indexes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= RST_IMAGE_WIDTH;
            r_cfg_h    <= RST_IMAGE_HEIGHT;
            r_cfg_k    <= RST_KERNEL_SIZE;
            r_cfg_pad  <= RST_PAD_AMOUNT;
            r_cfg_step <= RST_STEP_SIZE;
            for (int i = 0; i < KC; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_cfg_w    <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_h    <= i_cfg_data[DIM_W-1:0];
                CFG_KERNEL_SIZE:  r_cfg_k    <= i_cfg_data[1:0];
                CFG_PAD_AMOUNT:   r_cfg_pad  <= i_cfg_data[1:0];
                CFG_STEP_SIZE:    r_cfg_step <= i_cfg_data[1:0];
                CFG_COEF_ROW0:    r_coef[0]  <= i_cfg_data;
                CFG_COEF_ROW1: begin
                    if (KC > 1) begin
                        r_coef[KC > 1 ? 1 : 0] <= i_cfg_data;
                    end
                end
                CFG_COEF_ROW2: begin
                    if (KC > 2) begin
                        r_coef[KC > 2 ? 2 : 0] <= i_cfg_data;
                    end
                end
                default: ;
            endcase
        end
    end

    // Clamp sizes: a zero width, height, kernel or step acts as one, oversize acts as the largest supported
    always_comb begin
        if (r_cfg_w == '0)                 w_eff = CW'(1);
        else if (32'(r_cfg_w) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
        else                               w_eff = CW'(r_cfg_w);

        if (r_cfg_h == '0)                 h_eff = CW'(1);
        else if (32'(r_cfg_h) > MAX_WIDTH) h_eff = CW'(MAX_WIDTH);
        else                               h_eff = CW'(r_cfg_h);

        if (32'(r_cfg_pad) > MAX_PAD) p_eff = 2'(MAX_PAD);
        else                          p_eff = r_cfg_pad;

        if (r_cfg_k == '0)        k_eff = 2'd1;
        else if (32'(r_cfg_k) > KC) k_eff = 2'(KC);
        else                      k_eff = r_cfg_k;

        s_eff = (r_cfg_step == '0) ? 2'd1 : r_cfg_step;

        pw = w_eff + (CW'(p_eff) << 1);
        ph = h_eff + (CW'(p_eff) << 1);
    end

    // ---------------------------------------------------------------
    // Raster position of the incoming sample
    // ---------------------------------------------------------------
    assign in_acc  = i_in_valid && o_in_ready;
    assign restart = (r_grid_row >= ph) || (r_grid_col >= pw);
    assign cur_row = restart ? '0 : r_grid_row;
    assign cur_col = restart ? '0 : r_grid_col;

    assign is_pad  = (cur_row < CW'(p_eff)) || (cur_row >= CW'(p_eff) + h_eff) ||
                     (cur_col < CW'(p_eff)) || (cur_col >= CW'(p_eff) + w_eff);
    assign cur_pix = is_pad ? '0 : i_pixel;

    // Window corner is (row - k + 1, col - k + 1); the window is the last one
    // on an axis when no further stride step fits in the padded grid.
    assign win_ok   = (cur_row >= CW'(k_eff) - CW'(1)) && (cur_col >= CW'(k_eff) - CW'(1));
    assign top      = cur_row - (CW'(k_eff) - CW'(1));
    assign left     = cur_col - (CW'(k_eff) - CW'(1));
    assign last_pos = ({2'b00, cur_row} + (CW+2)'(s_eff) + (CW+2)'(1) > {2'b00, ph}) &&
                      ({2'b00, cur_col} + (CW+2)'(s_eff) + (CW+2)'(1) > {2'b00, pw});

    always_comb begin
        n_grid_row = cur_row;
        n_grid_col = cur_col + CW'(1);
        if (cur_col + CW'(1) >= pw) begin
            n_grid_col = '0;
            n_grid_row = (cur_row + CW'(1) >= ph) ? '0 : cur_row + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_row <= '0;
            r_grid_col <= '0;
        end else if (in_acc) begin
            r_grid_row <= n_grid_row;
            r_grid_col <= n_grid_col;
        end
    end

    // Sweep the line store to zero after reset, one column a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(LINE_LEN - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Line store: read the column at accept, write it back in the next cycle.
    // A sample in stage 1 at the same column forwards its new word.
    // ---------------------------------------------------------------
    always_comb begin
        line_wdata = '0;
        line_wdata[PIX_W-1:0] = r_s1_pix;
        for (int i = 1; i < LR; i++) begin
            line_wdata[i*PIX_W +: PIX_W] = r_line_rd[(i-1)*PIX_W +: PIX_W];
        end
    end

    assign mem_we    = r_clr_busy || r_s1_vld;
    assign mem_waddr = r_clr_busy ? r_clr_addr : r_s1_col[AW-1:0];
    assign mem_wdata = r_clr_busy ? '0 : line_wdata;
    assign bypass    = r_s1_vld && (r_s1_col == cur_col);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_mem[mem_waddr] <= mem_wdata;
        end
        r_line_rd <= bypass ? line_wdata : r_line_mem[cur_col[AW-1:0]];
    end

    // ---------------------------------------------------------------
    // Stage 1: hold the sample and its window corner
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix  <= cur_pix;
            r_s1_col  <= cur_col;
            r_s1_win  <= win_ok;
            r_s1_top  <= top;
            r_s1_left <= left;
            r_s1_last <= last_pos;
        end
    end

    spc_stride_div #(.XW(CW)) u_div_row (
        .i_x    (r_s1_top),
        .i_step (s_eff),
        .o_quot (qrow),
        .o_exact(ex_row)
    );

    spc_stride_div #(.XW(CW)) u_div_col (
        .i_x    (r_s1_left),
        .i_step (s_eff),
        .o_quot (qcol),
        .o_exact(ex_col)
    );

    // Shift the window left and load the new column from the line store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MK; i++) begin
                for (int j = 0; j < MK; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (r_s1_vld) begin
            for (int i = 0; i < MK; i++) begin
                for (int j = 0; j + 1 < MK; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
            end
            r_win[MK-1][MK-1] <= r_s1_pix;
            for (int i = 0; i + 1 < MK; i++) begin
                r_win[MK-2-i][MK-1] <= r_line_rd[i*PIX_W +: PIX_W];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stages 2 to 4: products, row sums, total
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_prod <= 1'b0;
            r_s3_prod <= 1'b0;
            r_s4_prod <= 1'b0;
        end else begin
            r_s2_prod <= r_s1_vld && r_s1_win && ex_row && ex_col;
            r_s3_prod <= r_s2_prod;
            r_s4_prod <= r_s3_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_meta.sum  <= '0;
        r_s2_meta.row  <= OUT_IDX_W'(qrow);
        r_s2_meta.col  <= OUT_IDX_W'(qcol);
        r_s2_meta.done <= r_s1_last;
        r_s3_meta      <= r_s2_meta;
        r_s4_meta      <= r_s3_meta;
    end

    // The active k x k kernel covers the bottom-right corner of the window
    always_comb begin
        for (int i = 0; i < KC; i++) begin
            for (int j = 0; j < KC; j++) begin
                t_pixel pix;
                t_pixel cf;
                pix = '0;
                cf  = r_coef[i][j*PIX_W +: PIX_W];
                for (int kk = ((i > j) ? i : j) + 1; kk <= KC; kk++) begin
                    if (k_eff == 2'(kk)) begin
                        pix = r_win[MK-kk+i][MK-kk+j];
                    end
                end
                n_prod[i][j] = cf * pix;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < KC; i++) begin
            n_rsum[i] = '0;
            for (int j = 0; j < KC; j++) begin
                n_rsum[i] = n_rsum[i] + {{2{r_s3_mul[i][j][PROD_W-1]}}, r_s3_mul[i][j]};
            end
        end
    end

    always_comb begin
        tsum = '0;
        for (int i = 0; i < KC; i++) begin
            tsum = tsum + {{2{r_s4_rsum[i][RSUM_W-1]}}, r_s4_rsum[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_mul  <= n_prod;
        r_s4_rsum <= n_rsum;
    end

    // ---------------------------------------------------------------
    // Result queue; input credit counts the queued results plus those still in the pipeline
    // ---------------------------------------------------------------
    always_comb begin
        push_res      = r_s4_meta;
        push_res.sum  = tsum[SUM_W-1:0];
    end

    assign push = r_s4_prod;
    assign pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcnt   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FPW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FPW'(1);
            end
            case ({push, pop})
                2'b10:   r_fcnt <= r_fcnt + FCW'(1);
                2'b01:   r_fcnt <= r_fcnt - FCW'(1);
                default: r_fcnt <= r_fcnt;
            endcase
        end
    end

    assign credit = (FCW+1)'(r_fcnt) + (FCW+1)'(r_s1_vld) + (FCW+1)'(r_s2_prod) +
                    (FCW+1)'(r_s3_prod) + (FCW+1)'(r_s4_prod);

    assign o_in_ready   = !r_clr_busy && (credit < (FCW+1)'(FDEPTH));
    assign o_out_valid  = (r_fcnt != '0);
    assign o_conv_sum   = r_fifo[r_rd_ptr].sum;
    assign o_out_row    = r_fifo[r_rd_ptr].row;
    assign o_out_col    = r_fifo[r_rd_ptr].col;
    assign o_frame_done = r_fifo[r_rd_ptr].done;

endmodule
